[src/tptu_pkg.sv]
// ----------------------------------------------------------------------------
// tptu_pkg
// Shared types and fixed widths of the TLB and page-table address translator.
// ----------------------------------------------------------------------------
package tptu_pkg;

   // fixed field widths of the request and response channels
   localparam int VA_WIDTH    = 16;
   localparam int FRAME_WIDTH = 8;
   localparam int TOTAL_WIDTH = 32;

   // controller states, one-hot
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } tptu_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;   // latch request, issue page-table read
      logic commit;    // resolve translation, update tables and totals
   } tptu_cmd_type;

endpackage

[src/tptu_ctrl.sv]
// ----------------------------------------------------------------------------
// tptu_ctrl
// Sequencer: accepts a request, runs the lookup state, strobes the response.
// ----------------------------------------------------------------------------
module tptu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   output tptu_pkg::tptu_cmd_type cmd
);
   import tptu_pkg::*;

   tptu_state_type state_ff;
   tptu_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   // next state
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response strobe follows the commit cycle
   assign rsp_valid_in = cmd.commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff == ST_LOOKUP);
   assign rsp_valid = rsp_valid_ff;

endmodule

[src/tptu_datapath.sv]
// ----------------------------------------------------------------------------
// tptu_datapath
// TLB shift register with parallel compare, page-table memory with valid bits,
// frame allocator, saturating totals and registered response fields.
// ----------------------------------------------------------------------------
module tptu_datapath #(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_COUNT  = 256,
   parameter int OFFSET_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tptu_pkg::tptu_cmd_type              cmd,
   input  logic [tptu_pkg::VA_WIDTH-1:0]       req_virtual_address,
   output logic [tptu_pkg::VA_WIDTH-1:0]       rsp_physical_address,
   output logic [tptu_pkg::FRAME_WIDTH-1:0]    rsp_frame_number,
   output logic                                rsp_tlb_hit,
   output logic                                rsp_page_fault,
   output logic [tptu_pkg::TOTAL_WIDTH-1:0]    rsp_address_total,
   output logic [tptu_pkg::TOTAL_WIDTH-1:0]    rsp_fault_total,
   output logic [tptu_pkg::TOTAL_WIDTH-1:0]    rsp_hit_total
);
   import tptu_pkg::*;

   localparam int PAGE_BITS = $clog2(PAGE_COUNT);
   localparam int FILL_BITS = $clog2(TLB_ENTRIES + 1);

   // page number of the incoming request, modulo the page count
   logic [PAGE_BITS-1:0] req_page;
   assign req_page = PAGE_BITS'(req_virtual_address >> OFFSET_BITS);

   // captured request and page-table read data
   logic [PAGE_BITS-1:0]   page_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [PAGE_BITS-1:0]   pt_frame_ff;
   logic                   pt_hit_ff;

   // page table storage
   logic [PAGE_BITS-1:0]   pt_mem [PAGE_COUNT];
   logic [PAGE_COUNT-1:0]  pt_valid_ff;
   logic [PAGE_COUNT-1:0]  pt_valid_in;

   // tlb storage, newest entry at index zero
   logic [PAGE_BITS-1:0]   tlb_tag_ff   [TLB_ENTRIES];
   logic [PAGE_BITS-1:0]   tlb_frame_ff [TLB_ENTRIES];
   logic [FILL_BITS-1:0]   tlb_fill_ff;
   logic [FILL_BITS-1:0]   tlb_fill_in;

   // frame allocator and totals
   logic [PAGE_BITS:0]     next_frame_ff;
   logic [PAGE_BITS:0]     next_frame_in;
   logic [TOTAL_WIDTH-1:0] addr_total_ff;
   logic [TOTAL_WIDTH-1:0] addr_total_in;
   logic [TOTAL_WIDTH-1:0] fault_total_ff;
   logic [TOTAL_WIDTH-1:0] fault_total_in;
   logic [TOTAL_WIDTH-1:0] hit_total_ff;
   logic [TOTAL_WIDTH-1:0] hit_total_in;

   // response registers
   logic [VA_WIDTH-1:0]    phys_ff;
   logic [FRAME_WIDTH-1:0] frame_out_ff;
   logic                   hit_out_ff;
   logic                   fault_out_ff;

   // lookup decision
   logic                   tlb_match;
   logic [PAGE_BITS-1:0]   tlb_frame;
   logic                   miss_fault;
   logic                   do_fault;
   logic [PAGE_BITS-1:0]   frame_sel;

   // page-table read on capture, write of new mapping on fault
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         page_ff     <= req_page;
         offset_ff   <= req_virtual_address[OFFSET_BITS-1:0];
         pt_frame_ff <= pt_mem[req_page];
         pt_hit_ff   <= pt_valid_ff[req_page];
      end
      if (do_fault) begin
         pt_mem[page_ff] <= frame_sel;
      end
   end

   // parallel tag compare over the filled entries, highest index wins
   always_comb begin
      tlb_match = 1'b0;
      tlb_frame = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if ((FILL_BITS'(i) < tlb_fill_ff) && (tlb_tag_ff[i] == page_ff)) begin
            tlb_match = 1'b1;
            tlb_frame = tlb_frame_ff[i];
         end
      end
   end

   // choose source of the frame
   assign miss_fault = !tlb_match && !pt_hit_ff;
   assign do_fault   = cmd.commit && miss_fault;

   always_comb begin
      if (tlb_match) begin
         frame_sel = tlb_frame;
      end else if (pt_hit_ff) begin
         frame_sel = pt_frame_ff;
      end else begin
         frame_sel = next_frame_ff[PAGE_BITS-1:0];
      end
   end

   // next values of control state
   always_comb begin
      pt_valid_in = pt_valid_ff;
      if (do_fault) begin
         pt_valid_in[page_ff] = 1'b1;
      end
   end

   assign tlb_fill_in   = (do_fault && (tlb_fill_ff != FILL_BITS'(TLB_ENTRIES)))
                          ? tlb_fill_ff + 1'b1 : tlb_fill_ff;
   assign next_frame_in = do_fault ? next_frame_ff + 1'b1 : next_frame_ff;

   // saturating totals
   assign addr_total_in  = (cmd.commit && (addr_total_ff != '1))
                           ? addr_total_ff + 1'b1 : addr_total_ff;
   assign fault_total_in = (do_fault && (fault_total_ff != '1))
                           ? fault_total_ff + 1'b1 : fault_total_ff;
   assign hit_total_in   = (cmd.commit && tlb_match && (hit_total_ff != '1))
                           ? hit_total_ff + 1'b1 : hit_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff    <= '0;
         tlb_fill_ff    <= '0;
         next_frame_ff  <= '0;
         addr_total_ff  <= '0;
         fault_total_ff <= '0;
         hit_total_ff   <= '0;
      end else begin
         pt_valid_ff    <= pt_valid_in;
         tlb_fill_ff    <= tlb_fill_in;
         next_frame_ff  <= next_frame_in;
         addr_total_ff  <= addr_total_in;
         fault_total_ff <= fault_total_in;
         hit_total_ff   <= hit_total_in;
      end
   end

   // tlb fifo: push new mapping at the front, oldest falls off the back
   always_ff @(posedge clock) begin
      if (do_fault) begin
         tlb_tag_ff[0]   <= page_ff;
         tlb_frame_ff[0] <= frame_sel;
         for (int i = 1; i < TLB_ENTRIES; i++) begin
            tlb_tag_ff[i]   <= tlb_tag_ff[i-1];
            tlb_frame_ff[i] <= tlb_frame_ff[i-1];
         end
      end
   end

   // response fields
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         phys_ff      <= VA_WIDTH'({frame_sel, offset_ff});
         frame_out_ff <= FRAME_WIDTH'(frame_sel);
         hit_out_ff   <= tlb_match;
         fault_out_ff <= miss_fault;
      end
   end

   assign rsp_physical_address = phys_ff;
   assign rsp_frame_number     = frame_out_ff;
   assign rsp_tlb_hit          = hit_out_ff;
   assign rsp_page_fault       = fault_out_ff;
   assign rsp_address_total    = addr_total_ff;
   assign rsp_fault_total      = fault_total_ff;
   assign rsp_hit_total        = hit_total_ff;

endmodule

[src/tlb_page_table_translator_unit.sv]
// ----------------------------------------------------------------------------
// tlb_page_table_translator_unit
// The response strobe is registered from the commit in the lookup state, which
// the accepting edge enters; the response fields are registered with it.
// No new address is taken while busy in the lookup state, in which a fault
// writes back the page-table entry that was read in the capture cycle.
// The receiver cannot stall; each response is shown for exactly one cycle.
// Reset clears tlb fill, page valid bits, frame allocator and all totals.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_unit #(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_COUNT  = 256,
   parameter int OFFSET_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tptu_pkg::VA_WIDTH-1:0]       req_virtual_address,
   output logic                                rsp_valid,
   output logic [tptu_pkg::VA_WIDTH-1:0]       rsp_physical_address,
   output logic [tptu_pkg::FRAME_WIDTH-1:0]    rsp_frame_number,
   output logic                                rsp_tlb_hit,
   output logic                                rsp_page_fault,
   output logic [tptu_pkg::TOTAL_WIDTH-1:0]    rsp_address_total,
   output logic [tptu_pkg::TOTAL_WIDTH-1:0]    rsp_fault_total,
   output logic [tptu_pkg::TOTAL_WIDTH-1:0]    rsp_hit_total
);
   import tptu_pkg::*;

   tptu_cmd_type cmd;

   // sequencer
   tptu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // translation datapath
   tptu_datapath #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .PAGE_COUNT  (PAGE_COUNT),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_virtual_address  (req_virtual_address),
      .rsp_physical_address (rsp_physical_address),
      .rsp_frame_number     (rsp_frame_number),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_address_total    (rsp_address_total),
      .rsp_fault_total      (rsp_fault_total),
      .rsp_hit_total        (rsp_hit_total)
   );

endmodule

[src/tptu_checker.sv]
// ----------------------------------------------------------------------------
// tptu_checker
// Port-level checks of sequencing and response consistency, bound to the top.
// ----------------------------------------------------------------------------
module tptu_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic                             rsp_tlb_hit,
   input logic                             rsp_page_fault,
   input logic [tptu_pkg::TOTAL_WIDTH-1:0] rsp_fault_total,
   input logic [tptu_pkg::TOTAL_WIDTH-1:0] rsp_hit_total
);
   import tptu_pkg::*;

   // an accepted transfer occupies the block for the lookup state
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("no lookup cycle after accepted transfer");

   // every lookup state ends in exactly one response strobe
   assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("lookup not followed by response");

   // responses are never back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // a tlb hit cannot also be a page fault
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tlb_hit && rsp_page_fault))
      else $error("hit and fault flagged together");

   // flagged events are reflected in their totals
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_tlb_hit || (rsp_hit_total != '0)) &&
                     (!rsp_page_fault || (rsp_fault_total != '0))))
      else $error("total not counting flagged event");

endmodule

bind tlb_page_table_translator_unit tptu_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_tlb_hit     (rsp_tlb_hit),
   .rsp_page_fault  (rsp_page_fault),
   .rsp_fault_total (rsp_fault_total),
   .rsp_hit_total   (rsp_hit_total)
);

[tb/tlb_page_table_translator_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator_unit_tb
// Drives virtual addresses into the translator and checks every response
// against typed table values or a behavioural model of the TLB, page table
// and frame allocator. A short table of directed addresses is followed by
// random traffic, which mostly revisits pages held in the TLB or already
// mapped, so that TLB hits, page-table hits and faults all occur often.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_unit_tb;

   import tptu_pkg::*;

   localparam int TLB_DEPTH     = 16;
   localparam int PAGE_TOTAL    = 256;
   localparam int OFFSET_W      = 8;
   localparam int RANDOM_ITEMS  = 630;
   localparam int MAX_REPORTS   = 10;
   localparam int DRAIN_CYCLES  = 8;

   typedef struct packed {
      logic [VA_WIDTH-1:0]    phys_addr;
      logic [FRAME_WIDTH-1:0] frame;
      logic                   tlb_hit;
      logic                   fault;
      logic [TOTAL_WIDTH-1:0] addr_total;
      logic [TOTAL_WIDTH-1:0] fault_total;
      logic [TOTAL_WIDTH-1:0] hit_total;
   } translation_type;

   typedef struct {
      logic [VA_WIDTH-1:0] vaddr;
      bit                  typed;
      translation_type     want;
   } address_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [VA_WIDTH-1:0]    req_virtual_address;
   logic                   rsp_valid;
   logic [VA_WIDTH-1:0]    rsp_physical_address;
   logic [FRAME_WIDTH-1:0] rsp_frame_number;
   logic                   rsp_tlb_hit;
   logic                   rsp_page_fault;
   logic [TOTAL_WIDTH-1:0] rsp_address_total;
   logic [TOTAL_WIDTH-1:0] rsp_fault_total;
   logic [TOTAL_WIDTH-1:0] rsp_hit_total;

   // model state
   logic [7:0]             tlb_tags [TLB_DEPTH];
   logic [8:0]             tlb_frame_ids [TLB_DEPTH];
   int                     tlb_count;
   bit                     page_mapped [PAGE_TOTAL];
   logic [8:0]             page_frame_ids [PAGE_TOTAL];
   logic [8:0]             frame_alloc;
   logic [TOTAL_WIDTH-1:0] addr_count;
   logic [TOTAL_WIDTH-1:0] fault_count;
   logic [TOTAL_WIDTH-1:0] hit_count;
   logic [7:0]             mapped_pages [$];

   translation_type        expected_translations [$];
   address_row_type        address_table [$];
   int                     error_count;
   int                     checked_count;
   int                     seen_tlb_hits;
   int                     seen_faults;
   int                     seen_table_hits;
   int                     burst_left;

   tlb_page_table_translator_unit dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_physical_address (rsp_physical_address),
      .rsp_frame_number     (rsp_frame_number),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_address_total    (rsp_address_total),
      .rsp_fault_total      (rsp_fault_total),
      .rsp_hit_total        (rsp_hit_total)
   );

   always #5 clock = ~clock;

   function automatic logic [TOTAL_WIDTH-1:0] sat_add1(input logic [TOTAL_WIDTH-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // translate one address and advance the model state
   function automatic translation_type translate_address(input logic [VA_WIDTH-1:0] vaddr);
      translation_type res;
      logic [7:0]      page;
      logic [7:0]      offset;
      logic [8:0]      frame;
      bit              hit;
      bit              fault;
      int              keep;
      page   = vaddr[VA_WIDTH-1:OFFSET_W];
      offset = vaddr[OFFSET_W-1:0];
      frame  = '0;
      hit    = 1'b0;
      fault  = 1'b0;
      addr_count = sat_add1(addr_count);
      // parallel tlb compare over valid entries
      for (int i = 0; i < tlb_count; i++) begin
         if (tlb_tags[i] == page) begin
            hit   = 1'b1;
            frame = tlb_frame_ids[i];
         end
      end
      if (hit) begin
         hit_count = sat_add1(hit_count);
      end else if (!page_mapped[page]) begin
         // fault: allocate frame, push mapping to front of tlb
         fault                = 1'b1;
         frame                = frame_alloc;
         page_frame_ids[page] = frame;
         page_mapped[page]    = 1'b1;
         mapped_pages.push_back(page);
         frame_alloc          = frame_alloc + 1'b1;
         fault_count          = sat_add1(fault_count);
         keep = (tlb_count >= TLB_DEPTH) ? TLB_DEPTH - 1 : tlb_count;
         for (int i = keep; i > 0; i--) begin
            tlb_tags[i]      = tlb_tags[i-1];
            tlb_frame_ids[i] = tlb_frame_ids[i-1];
         end
         tlb_tags[0]      = page;
         tlb_frame_ids[0] = frame;
         tlb_count        = keep + 1;
      end else begin
         frame = page_frame_ids[page];
      end
      res.phys_addr   = {frame[7:0], offset};
      res.frame       = frame[7:0];
      res.tlb_hit     = hit;
      res.fault       = fault;
      res.addr_total  = addr_count;
      res.fault_total = fault_count;
      res.hit_total   = hit_count;
      return res;
   endfunction

   task automatic add_row(input logic [VA_WIDTH-1:0] vaddr, input bit typed,
                          input logic [VA_WIDTH-1:0] pa, input logic [7:0] frame,
                          input logic hit, input logic fault, input int at,
                          input int ft, input int ht);
      address_row_type row;
      row.vaddr            = vaddr;
      row.typed            = typed;
      row.want.phys_addr   = pa;
      row.want.frame       = frame;
      row.want.tlb_hit     = hit;
      row.want.fault       = fault;
      row.want.addr_total  = at;
      row.want.fault_total = ft;
      row.want.hit_total   = ht;
      address_table.push_back(row);
   endtask

   // one request transfer, with random bursts and gaps on the sender side
   task automatic send_address(input logic [VA_WIDTH-1:0] vaddr, input bit typed,
                               input translation_type want);
      translation_type model;
      int              gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      start               <= 1'b1;
      req_virtual_address <= vaddr;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      model = translate_address(vaddr);
      expected_translations.push_back(typed ? want : model);
   endtask

   // response checker
   always @(posedge clock) begin
      translation_type got;
      translation_type want;
      if (!reset && rsp_valid) begin
         got.phys_addr   = rsp_physical_address;
         got.frame       = rsp_frame_number;
         got.tlb_hit     = rsp_tlb_hit;
         got.fault       = rsp_page_fault;
         got.addr_total  = rsp_address_total;
         got.fault_total = rsp_fault_total;
         got.hit_total   = rsp_hit_total;
         if (expected_translations.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: response with nothing outstanding: pa=%h", $realtime,
                        got.phys_addr);
         end else begin
            want = expected_translations.pop_front();
            checked_count++;
            if (got.phys_addr !== want.phys_addr || got.frame !== want.frame ||
                got.tlb_hit !== want.tlb_hit || got.fault !== want.fault ||
                got.addr_total !== want.addr_total ||
                got.fault_total !== want.fault_total ||
                got.hit_total !== want.hit_total) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch exp pa=%h fr=%h hit=%b flt=%b tot=%0d/%0d/%0d",
                           $realtime, want.phys_addr, want.frame, want.tlb_hit,
                           want.fault, want.addr_total, want.fault_total, want.hit_total);
                  $display("%0t:          got pa=%h fr=%h hit=%b flt=%b tot=%0d/%0d/%0d",
                           $realtime, got.phys_addr, got.frame, got.tlb_hit, got.fault,
                           got.addr_total, got.fault_total, got.hit_total);
               end
            end
            if (want.tlb_hit) seen_tlb_hits++;
            else if (want.fault) seen_faults++;
            else seen_table_hits++;
         end
      end
   end

   // run limit
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // stimulus
   initial begin
      logic [7:0]      page;
      int              pick;
      translation_type none;
      start               = 1'b0;
      req_virtual_address = '0;
      reset               = 1'b1;
      error_count         = 0;
      checked_count       = 0;
      seen_tlb_hits       = 0;
      seen_faults         = 0;
      seen_table_hits     = 0;
      burst_left          = 0;
      none                = '0;
      tlb_count           = 0;
      frame_alloc         = '0;
      addr_count          = '0;
      fault_count         = '0;
      hit_count           = '0;
      for (int i = 0; i < PAGE_TOTAL; i++) page_mapped[i] = 1'b0;
      for (int i = 0; i < TLB_DEPTH; i++) begin
         tlb_tags[i]      = '0;
         tlb_frame_ids[i] = '0;
      end

      // directed table: extremes, tlb hit, tlb overflow, page-table hit
      add_row(16'h0000, 1, 16'h0000, 8'h00, 1'b0, 1'b1, 1, 1, 0);
      add_row(16'h00FF, 1, 16'h00FF, 8'h00, 1'b1, 1'b0, 2, 1, 1);
      add_row(16'hFFFF, 1, 16'h01FF, 8'h01, 1'b0, 1'b1, 3, 2, 1);
      add_row(16'hFF00, 1, 16'h0100, 8'h01, 1'b1, 1'b0, 4, 2, 2);
      // fill the tlb past its depth so that page zero drops out
      for (int p = 1; p <= 15; p++)
         add_row({p[7:0], 8'hA5 ^ p[7:0]}, 0, '0, '0, 1'b0, 1'b0, 0, 0, 0);
      // page zero now resolves from the page table and is not refilled
      add_row(16'h0080, 1, 16'h0080, 8'h00, 1'b0, 1'b0, 20, 17, 2);
      add_row(16'h00FF, 1, 16'h00FF, 8'h00, 1'b0, 1'b0, 21, 17, 2);
      add_row(16'hFF55, 0, '0, '0, 1'b0, 1'b0, 0, 0, 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (address_table[i])
         send_address(address_table[i].vaddr, address_table[i].typed,
                      address_table[i].want);

      // random traffic, biased towards pages already seen
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40 && tlb_count > 0)
            page = tlb_tags[$urandom_range(0, tlb_count - 1)];
         else if (pick < 70 && mapped_pages.size() > 0)
            page = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
         else if (pick < 74)
            page = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         else
            page = 8'($urandom_range(0, 255));
         send_address({page, 8'($urandom_range(0, 255))}, 0, none);
      end
      @(negedge clock);
      start <= 1'b0;

      // drain outstanding responses
      while (expected_translations.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      error_count += expected_translations.size();
      $display("checked %0d translations: %0d tlb hits, %0d page-table hits, %0d faults",
               checked_count, seen_tlb_hits, seen_table_hits, seen_faults);
      $display("pages mapped %0d, errors %0d", mapped_pages.size(), error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
